// ===== hdl/jse_pkg.sv =====
// Shared types, codes and helpers for the JSON string escaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jse_pkg;

  localparam int unsigned POS_W   = 16;  // write position / index width
  localparam int unsigned SEQ_MAX = 6;   // longest escape: \u00XX
  localparam int unsigned LEN_W   = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [7:0] C_BS = 8'h08;
  localparam logic [7:0] C_HT = 8'h09;
  localparam logic [7:0] C_LF = 8'h0A;
  localparam logic [7:0] C_FF = 8'h0C;
  localparam logic [7:0] C_CR = 8'h0D;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_BEGIN_BAD,
    OP_CHAR,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_e;

  // One classified item, waiting for the emitter.
  typedef struct packed {
    op_e                          op;
    logic [SEQ_MAX-1:0][7:0]      seq;
    logic [LEN_W-1:0]             len;
    logic [POS_W-1:0]             start;
  } entry_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CH_ZERO + {4'd0, nib};
    else             r = CH_LOW_A + {4'd0, nib - 4'd10};
    return r;
  endfunction

endpackage

// ===== hdl/jse_front.sv =====
// Front end: accepts input beats, drops unused commands and expands each
// character into its escape sequence. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_front import jse_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [POS_W-1:0] start_offset_i,
  input  logic [15:0]      capacity_i,
  input  logic             q_full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o       = '0;
    entry_o.start = start_offset_i;
    entry_o.op    = OP_CHAR;
    push_o        = 1'b0;
    case (command_i)
      CMD_BEGIN: begin
        push_o         = accept;
        entry_o.op     = (start_offset_i >= capacity_i) ? OP_BEGIN_BAD : OP_BEGIN;
        entry_o.seq[0] = CH_QUOTE;
        entry_o.len    = LEN_W'(1);
      end
      CMD_FINISH: begin
        push_o         = accept;
        entry_o.op     = OP_FINISH;
        entry_o.seq[0] = CH_QUOTE;
        entry_o.len    = LEN_W'(1);
      end
      CMD_CHAR: begin
        push_o = accept;
        if (data_byte_i inside {CH_QUOTE, CH_BSLASH}) begin
          entry_o.seq[0] = CH_BSLASH;
          entry_o.seq[1] = data_byte_i;
          entry_o.len    = LEN_W'(2);
        end else if (data_byte_i < CH_SPACE) begin
          entry_o.seq[0] = CH_BSLASH;
          entry_o.len    = LEN_W'(2);
          case (data_byte_i)
            C_BS:    entry_o.seq[1] = CH_LOW_B;
            C_FF:    entry_o.seq[1] = CH_LOW_F;
            C_LF:    entry_o.seq[1] = CH_LOW_N;
            C_CR:    entry_o.seq[1] = CH_LOW_R;
            C_HT:    entry_o.seq[1] = CH_LOW_T;
            default: begin
              entry_o.seq[1] = CH_LOW_U;
              entry_o.seq[2] = CH_ZERO;
              entry_o.seq[3] = CH_ZERO;
              entry_o.seq[4] = hex_digit(data_byte_i[7:4]);
              entry_o.seq[5] = hex_digit(data_byte_i[3:0]);
              entry_o.len    = LEN_W'(SEQ_MAX);
            end
          endcase
        end else begin
          entry_o.seq[0] = data_byte_i;
          entry_o.len    = LEN_W'(1);
        end
      end
      default: push_o = 1'b0;  // unused command: accepted, no effect
    endcase
  end

endmodule

// ===== hdl/jse_queue.sv =====
// Two-entry queue of classified items between front end and emitter.
// Depends on jse_pkg for the entry type.
`timescale 1ns / 1ps

module jse_queue import jse_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t     mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// ===== hdl/jse_back.sv =====
// Emitter: walks the head item's sequence one byte per cycle while the
// output is not stalled, tracks the write position and error state, and
// drives the output register. Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_back import jse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      capacity_i,
  input  logic             q_valid_i,
  input  entry_t           q_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [POS_W-1:0] write_index_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic [POS_W-1:0] idx_q, idx_d;
  status_e          st_q, st_d;
  logic             last_q, last_d;
  logic [POS_W-1:0] wp_q, wp_d;
  logic             err_q, err_d;
  logic [LEN_W-1:0] k_q, k_d;

  logic             adv;
  logic             do_emit;
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   nxt;
  logic             no_space;
  logic             seq_end;

  assign adv      = !valid_q || !out_stall_i;
  assign pos      = (q_entry_i.op == OP_BEGIN) ? q_entry_i.start : wp_q;
  assign nxt      = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};
  assign no_space = nxt[POS_W] || (nxt >= {{(POS_W+1-16){1'b0}}, capacity_i});
  assign seq_end  = ((k_q + LEN_W'(1)) == q_entry_i.len);

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    idx_d   = idx_q;
    st_d    = st_q;
    last_d  = last_q;
    wp_d    = wp_q;
    err_d   = err_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    do_emit = 1'b0;
    if (adv) begin
      valid_d = 1'b0;
      if (q_valid_i) begin
        case (q_entry_i.op)
          OP_BEGIN_BAD: begin
            valid_d = 1'b1;
            byte_d  = 8'd0;
            idx_d   = q_entry_i.start;
            st_d    = ST_BAD_START;
            last_d  = 1'b1;
            err_d   = 1'b1;
            pop_o   = 1'b1;
          end
          OP_BEGIN: begin
            err_d   = 1'b0;
            do_emit = 1'b1;
          end
          OP_CHAR, OP_FINISH: begin
            if (err_q) pop_o = 1'b1;  // outside a string: dropped
            else       do_emit = 1'b1;
          end
          default: pop_o = 1'b1;
        endcase
      end
      if (do_emit) begin
        valid_d = 1'b1;
        idx_d   = pos;
        if (no_space) begin
          byte_d = 8'd0;
          st_d   = ST_NO_SPACE;
          last_d = 1'b1;
          err_d  = 1'b1;
          pop_o  = 1'b1;
          k_d    = '0;
        end else begin
          byte_d = q_entry_i.seq[k_q];
          st_d   = ST_OK;
          last_d = seq_end;
          wp_d   = nxt[POS_W-1:0];
          if (seq_end) begin
            pop_o = 1'b1;
            k_d   = '0;
            if (q_entry_i.op == OP_FINISH) err_d = 1'b1;
          end else begin
            k_d = k_q + LEN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wp_q    <= '0;
      err_q   <= 1'b1;
      k_q     <= '0;
    end else begin
      valid_q <= valid_d;
      wp_q    <= wp_d;
      err_q   <= err_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    idx_q  <= idx_d;
    st_q   <= st_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign write_index_o = idx_q;
  assign status_o      = st_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/json_string_escaper.sv =====
// Top level of the JSON string escaper: capacity register, front end,
// item queue and emitter. Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//   channel  direction  handshake              beat
//   in       input      in_valid_i/in_stall_o  command, data_byte, start_offset
//   out      output     out_valid_o/out_stall_i out_byte, write_index, status, last
//   cfg      input      cfg_valid_i/cfg_ready_o buffer_capacity
//
// Input beats are accepted every cycle while the two-entry queue has room.
// The emitter puts out one byte per cycle unless stalled: a plain character
// gives 1 byte, a short escape 2, a \u00XX escape 6, an error result 1, a drop 0.
// Output stall holds the output register and, once the queue fills, the input.
// Reset clears control state only (capacity 0, idle until begin); no sweep.
`timescale 1ns / 1ps

module json_string_escaper import jse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [POS_W-1:0] start_offset_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [POS_W-1:0] write_index_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i
);

  logic [15:0] cap_q, cap_d;
  logic        q_full, q_push, q_pop, q_valid;
  entry_t      f_entry, q_entry;

  assign cfg_ready_o = 1'b1;
  assign cap_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= '0;
    else         cap_q <= cap_d;
  end

  jse_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .start_offset_i (start_offset_i),
    .capacity_i     (cap_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .entry_o        (f_entry)
  );

  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  jse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_i    (cap_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .write_index_o (write_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // an error result always ends its item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (out_byte_o == 8'd0))
    else $error("error result carries a byte");

  // rest of an escape follows at once, at the next position
  a_seq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (status_o == ST_OK) && !last_o
    |=> out_valid_o && (write_index_o == $past(write_index_o) + 16'd1))
    else $error("escape sequence broken");
`endif

endmodule

// ===== test/tb_json_string_escaper.sv =====
// Self-checking testbench for json_string_escaper: directed and random command streams,
// a scoreboard that predicts every escaped byte beat, random input bursts and output stalls.
// Depends on jse_pkg and the json_string_escaper RTL only.
`timescale 1ns / 1ps

module tb_json_string_escaper;
  import jse_pkg::*;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;   // no such command, must be dropped
  localparam int          DRAIN_CYCLES = 24;     // two queued items plus a 6-beat escape
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 44;

  typedef struct {
    logic [7:0]       b;
    logic [POS_W-1:0] idx;
    status_e          st;
    logic             last;
  } beat_t;

  // Tracks write position and idle state; turns each command into the beats it must cause.
  class escaped_byte_board;
    logic [15:0]      capacity = '0;
    logic [POS_W-1:0] wr_pos = '0;
    logic             idle = 1'b1;
    beat_t            pending_bytes[$];
    string            hex_chars = "0123456789abcdef";
    int               errors = 0;
    int               n_items = 0;
    int               n_checked = 0;
    int               n_escapes = 0;
    int               n_nospace = 0;
    int               n_badstart = 0;

    function void push_beat(logic [7:0] b, logic [POS_W-1:0] idx, status_e st, logic last);
      beat_t e;
      e.b = b;
      e.idx = idx;
      e.st = st;
      e.last = last;
      pending_bytes.push_back(e);
    endfunction

    // One slot stays reserved for the terminator, so a byte needs pos+1 < capacity.
    function void emit_bytes(logic [7:0] esc [SEQ_MAX], int n);
      logic [POS_W:0] nxt;
      int             k;
      for (k = 0; k < n; k++) begin
        nxt = {1'b0, wr_pos} + 1'b1;
        if (nxt >= {1'b0, capacity}) begin
          push_beat(8'h00, wr_pos, ST_NO_SPACE, 1'b1);
          idle = 1'b1;
          n_nospace++;
          return;
        end
        push_beat(esc[k], wr_pos, ST_OK, k == n - 1);
        wr_pos = nxt[POS_W-1:0];
      end
    endfunction

    function int escape_item(logic [1:0] cmd, logic [7:0] ch, logic [POS_W-1:0] start);
      logic [7:0] esc [SEQ_MAX];
      int         n;
      int         q0;
      q0 = pending_bytes.size();
      n = 0;
      n_items++;
      case (cmd)
        CMD_BEGIN: begin
          if (start >= capacity) begin
            push_beat(8'h00, start, ST_BAD_START, 1'b1);
            idle = 1'b1;
            n_badstart++;
          end else begin
            wr_pos = start;
            idle = 1'b0;
            esc[0] = CH_QUOTE;
            emit_bytes(esc, 1);
          end
        end
        CMD_FINISH: begin
          if (!idle) begin
            esc[0] = CH_QUOTE;
            emit_bytes(esc, 1);
            idle = 1'b1;
          end
        end
        CMD_CHAR: begin
          if (!idle) begin
            if (ch == CH_QUOTE || ch == CH_BSLASH) begin
              esc[0] = CH_BSLASH;
              esc[1] = ch;
              n = 2;
            end else if (ch < CH_SPACE) begin
              esc[0] = CH_BSLASH;
              n = 2;
              case (ch)
                C_BS: esc[1] = CH_LOW_B;
                C_FF: esc[1] = CH_LOW_F;
                C_LF: esc[1] = CH_LOW_N;
                C_CR: esc[1] = CH_LOW_R;
                C_HT: esc[1] = CH_LOW_T;
                default: begin
                  esc[1] = CH_LOW_U;
                  esc[2] = CH_ZERO;
                  esc[3] = CH_ZERO;
                  esc[4] = hex_chars[ch[7:4]];
                  esc[5] = hex_chars[ch[3:0]];
                  n = 6;
                end
              endcase
            end else begin
              esc[0] = ch;
              n = 1;
            end
            if (n > 1) n_escapes++;
            emit_bytes(esc, n);
          end
        end
        default: ;
      endcase
      return pending_bytes.size() - q0;
    endfunction

    function void check_byte(logic [7:0] b, logic [POS_W-1:0] idx, logic [1:0] st, logic last);
      beat_t e;
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: out_byte %h write_index %0d status %0d last %b",
               b, idx, st, last);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      n_checked++;
      if (b !== e.b) begin
        $error("out_byte: expected %h, got %h", e.b, b);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("write_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       command_i;
  logic [7:0]       data_byte_i;
  logic [POS_W-1:0] start_offset_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_byte_o;
  logic [POS_W-1:0] write_index_o;
  logic [1:0]       status_o;
  logic             last_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [15:0]      cfg_data_i;

  escaped_byte_board board;
  int                burst_left = 0;
  int                n_live = 0;     // accepted items that caused at least one beat
  int                n_cfg = 0;

  json_string_escaper u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .start_offset_i (start_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .write_index_o  (write_index_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stretches of no stall, light, medium and heavy stalling.
  initial begin : stall_pattern
    int mode = 0;
    int run = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(10, 80);
      end
      run--;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_byte(out_byte_o, write_index_o, status_o, last_o);
  end

  initial begin : watchdog
    int unsigned cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Holds a beat until accepted; valid stays high into the next beat of a burst.
  task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic [POS_W-1:0] start);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    data_byte_i <= ch;
    start_offset_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (board.escape_item(cmd, ch, start) > 0) n_live++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.capacity = value;
    n_cfg++;
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 31));
      2:       return CH_QUOTE;
      3:       return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Begin, a run of characters, usually a finish; starts cluster near the buffer end.
  task automatic send_string(logic [15:0] cap, int max_len);
    int               c;
    int               len;
    int               k;
    logic [POS_W-1:0] start;
    c = cap;
    if (c == 0) start = 16'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0:       start = 16'($urandom_range(0, c - 1));
        1:       start = 16'($urandom);
        default: start = 16'($urandom_range((c > 24) ? c - 24 : 0, c - 1));
      endcase
    end
    send_item(CMD_BEGIN, 8'($urandom), start);
    len = $urandom_range(0, max_len);
    for (k = 0; k < len; k++) send_item(CMD_CHAR, rand_char(), 16'($urandom));
    if ($urandom_range(0, 6) != 0) send_item(CMD_FINISH, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(logic [15:0] cap);
    int items0;
    write_capacity(cap);
    items0 = board.n_items;
    while (board.n_items - items0 < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 8) send_string(cap, (cap < 64) ? 6 : 12);
      else send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin : main
    board = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CMD_BEGIN;
    data_byte_i <= '0;
    start_offset_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every escape class, idle drops, bad start, running out of space.
    write_capacity(16'd64);
    send_item(CMD_BEGIN, 8'h00, 16'd0);
    send_item(CMD_CHAR, CH_QUOTE, 16'd0);
    send_item(CMD_CHAR, CH_BSLASH, 16'd0);
    send_item(CMD_CHAR, C_BS, 16'd0);
    send_item(CMD_CHAR, C_FF, 16'd0);
    send_item(CMD_CHAR, C_LF, 16'd0);
    send_item(CMD_CHAR, C_CR, 16'd0);
    send_item(CMD_CHAR, C_HT, 16'd0);
    send_item(CMD_CHAR, 8'h00, 16'd0);
    send_item(CMD_CHAR, 8'h1F, 16'd0);
    send_item(CMD_CHAR, 8'h1B, 16'd0);
    send_item(CMD_CHAR, CH_SPACE, 16'd0);
    send_item(CMD_CHAR, 8'h7F, 16'd0);
    send_item(CMD_CHAR, 8'hFF, 16'd0);
    send_item(CMD_CHAR, 8'h41, 16'd0);
    send_item(CMD_FINISH, 8'h00, 16'd0);
    send_item(CMD_CHAR, 8'h41, 16'd0);       // outside a string: dropped
    send_item(CMD_UNUSED, 8'h41, 16'd0);
    send_item(CMD_FINISH, 8'h00, 16'd0);     // already closed: dropped
    send_item(CMD_BEGIN, 8'h00, 16'd64);     // start at capacity
    send_item(CMD_CHAR, 8'h41, 16'd0);
    send_item(CMD_BEGIN, 8'h00, 16'd60);
    send_item(CMD_CHAR, 8'h01, 16'd0);       // \u0001 runs out mid-escape
    send_item(CMD_CHAR, 8'h41, 16'd0);
    send_item(CMD_BEGIN, 8'h00, 16'd63);     // no room even for the quote
    drain();

    run_phase(16'd0);
    run_phase(16'hFFFF);
    run_phase(16'd1);
    run_phase(16'd2);
    run_phase(16'd9);
    run_phase(16'($urandom_range(3, 40)));
    run_phase(16'($urandom));
    run_phase(16'd300);

    $display("ran %0d commands (%0d producing output) over %0d capacity settings, %0d beats",
             board.n_items, n_live, n_cfg, board.n_checked);
    $display("escapes %0d, out-of-space ends %0d, rejected starts %0d",
             board.n_escapes, board.n_nospace, board.n_badstart);
    if (board.errors == 0 && board.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
